@@ rtl/rvcp_pkg.sv @@
// Package for the ray / vertical cylinder projection block.
// Holds widths, status and register codes, stage structs and the saturation helper.
// No dependencies.
package rvcp_pkg;

	// Default threshold on dx*dx + dy*dy at or below which the ray counts as parallel.
	localparam int unsigned PARALLEL_EPS_DEF = 26844;

	// Datapath widths.
	localparam int A_W    = 32;          // dx*dx + dy*dy
	localparam int H_W    = 50;          // dx*Dx + dy*Dy, signed
	localparam int RAD_W  = 94;          // a*r*r - cross^2
	localparam int ROOT_W = 47;          // floor(sqrt) of the radicand
	localparam int TRY_W  = RAD_W + 2;   // trial term of one root digit
	localparam int NUM_W  = 50;          // non-negative root numerator
	localparam int FRAC_W = 14;          // direction fraction bits
	localparam int DVD_W  = NUM_W + FRAC_W;
	localparam int QUO_W  = 47;          // t in Q.8, saturated to 2^47 - 1

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_NO_ROOT  = 2'd2,
		ST_BEHIND   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_AXIS_X     = 2'd0,
		REG_AXIS_Y     = 2'd1,
		REG_CYL_RADIUS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dz;
	} ray_t;

	// Data that travels with an item through both cell chains.
	typedef struct packed {
		ray_t                  ray;
		status_t               status;
		logic signed [H_W-1:0] h;
		logic [A_W-1:0]        a;
	} carry_t;

	typedef struct packed {
		carry_t            c;
		logic [RAD_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_stage_t;

	typedef struct packed {
		carry_t           c;
		logic [DVD_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic             ovf;
	} div_stage_t;

	// Clamp a wide signed sum to the 32 bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		logic signed [51:0] hi;
		logic signed [51:0] lo;
		hi = 52'sh7FFFFFFF;
		lo = -52'sh80000000;
		if (v > hi) begin
			return 32'sh7FFFFFFF;
		end else if (v < lo) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

@@ rtl/rvcp_if.sv @@
// Handshake interfaces of the ray / vertical cylinder projection block:
// ray input channel, point output channel and configuration write channel.
// No dependencies.
interface rvcp_ray_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] orig_x;
	logic signed [31:0] orig_y;
	logic signed [31:0] orig_z;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;

	modport source (output valid, orig_x, orig_y, orig_z, dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, orig_x, orig_y, orig_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface rvcp_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic [1:0]         hit_status;

	modport source (output valid, point_x, point_y, point_z, hit_status, input ready);
	modport sink (input valid, point_x, point_y, point_z, hit_status, output ready);
endinterface

interface rvcp_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/rvcp_sqrt_cell.sv @@
// One cell of the square root chain: settles one bit of the integer root.
// Depends on rvcp_pkg.
module rvcp_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_v,
	input  rvcp_pkg::sqrt_stage_t in_d,
	output logic                  out_v,
	output rvcp_pkg::sqrt_stage_t out_d
);

	logic [rvcp_pkg::TRY_W-1:0]  trial;
	logic [rvcp_pkg::TRY_W-1:0]  rext;
	logic [rvcp_pkg::TRY_W-1:0]  rdif;
	logic                        ge;
	logic [rvcp_pkg::ROOT_W-1:0] root_n;

	// Setting this bit raises root^2 by (root << (BIT+1)) + 2^(2*BIT).
	assign trial = (rvcp_pkg::TRY_W'(in_d.root) << (BIT + 1))
		| (rvcp_pkg::TRY_W'(1) << (2 * BIT));
	assign rext  = rvcp_pkg::TRY_W'(in_d.rem);
	assign ge    = rext >= trial;
	assign rdif  = rext - trial;

	always_comb begin
		root_n      = in_d.root;
		root_n[BIT] = ge;
	end

	// Valid bit of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (adv) begin
			out_v <= in_v;
		end
	end

	// Payload moves with the chain.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_d.c    <= in_d.c;
			out_d.rem  <= ge ? rdif[rvcp_pkg::RAD_W-1:0] : in_d.rem;
			out_d.root <= root_n;
		end
	end

endmodule

@@ rtl/rvcp_div_cell.sv @@
// One cell of the restoring divider chain: settles one quotient bit of t.
// Depends on rvcp_pkg.
module rvcp_div_cell #(
	parameter int BIT = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_v,
	input  rvcp_pkg::div_stage_t in_d,
	output logic                 out_v,
	output rvcp_pkg::div_stage_t out_d
);

	localparam int CW = rvcp_pkg::DVD_W + rvcp_pkg::A_W;

	logic [CW-1:0]              dvs;
	logic [CW-1:0]              rext;
	logic [CW-1:0]              rdif;
	logic                       ge;
	logic [rvcp_pkg::QUO_W-1:0] quo_n;

	// Subtract the divisor at this bit weight when the remainder allows it.
	assign dvs  = CW'(in_d.c.a) << BIT;
	assign rext = CW'(in_d.rem);
	assign ge   = rext >= dvs;
	assign rdif = rext - dvs;

	always_comb begin
		quo_n      = in_d.quo;
		quo_n[BIT] = ge;
	end

	// Valid bit of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (adv) begin
			out_v <= in_v;
		end
	end

	// Payload moves with the chain.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_d.c   <= in_d.c;
			out_d.rem <= ge ? rdif[rvcp_pkg::DVD_W-1:0] : in_d.rem;
			out_d.quo <= quo_n;
			out_d.ovf <= in_d.ovf;
		end
	end

endmodule

@@ rtl/ray_vertical_cylinder_projection.sv @@
// Throughput: one item per cycle while the output is not held; the front end is 7 stages,
// the square root is a chain of 47 cells, then 2 stages, a divider chain of 47 cells
// and 3 stages.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears all valid bits and the axis and radius registers to zero.
// Depends on rvcp_pkg, rvcp_if, rvcp_sqrt_cell and rvcp_div_cell.
module ray_vertical_cylinder_projection #(
	parameter int unsigned PARALLEL_EPS = rvcp_pkg::PARALLEL_EPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	rvcp_ray_if.sink            ray,
	rvcp_point_if.source        point,
	rvcp_cfg_if.sink            cfg
);

	localparam int ROOT_W = rvcp_pkg::ROOT_W;
	localparam int QUO_W  = rvcp_pkg::QUO_W;
	localparam int A_W    = rvcp_pkg::A_W;

	// Configuration registers.
	logic signed [31:0] axis_x_q;
	logic signed [31:0] axis_y_q;
	logic [30:0]        radius_q;

	logic adv;

	// Front end stage registers.
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	rvcp_pkg::ray_t        ray_s1, ray_s2, ray_s3, ray_s4, ray_s5, ray_s6;
	logic signed [32:0]    ddx_s1, ddy_s1;
	logic [30:0]           dxx_s1, dyy_s1;
	logic [61:0]           rr_s1, rr_s2;
	logic [A_W-1:0]        a_s2, a_s3, a_s4, a_s5, a_s6;
	logic signed [48:0]    pxx_s2, pyy_s2, pxy_s2, pyx_s2;
	logic signed [49:0]    h_s3, h_s4, h_s5, h_s6;
	logic signed [49:0]    cross_s3;
	logic [62:0]           p0_s3, p1_s3;
	logic                  par_s3, par_s4, par_s5, par_s6;
	logic [93:0]           lhs_s4, lhs_s5, lhs_s6;
	logic [48:0]           cabs_s4;
	logic [63:0]           cc0_s5;
	logic [48:0]           cc1_s5;
	logic [33:0]           cc2_s5;
	logic [96:0]           rhs_s6;

	// Combinational terms of the front end.
	logic signed [31:0] dxx_c, dyy_c;
	logic signed [49:0] cneg_c;
	logic [97:0]        diff_c;

	// Cell chains.
	rvcp_pkg::sqrt_stage_t sq [ROOT_W+1];
	logic [ROOT_W:0]       sq_v;
	rvcp_pkg::div_stage_t  dv [QUO_W+1];
	logic [QUO_W:0]        dv_v;

	// Numerator stage.
	logic                      v_s8;
	rvcp_pkg::carry_t          c_s8;
	rvcp_pkg::carry_t          c8_c;
	logic [rvcp_pkg::NUM_W-1:0] n_s8;
	logic signed [50:0]        hx_c, sx_c, n0_c, n1_c;

	// Back end.
	logic                  v_e1, v_e2;
	rvcp_pkg::ray_t        ray_e1, ray_e2;
	rvcp_pkg::status_t     st_e1, st_e2;
	logic [47:0]           pl_e1 [3];
	logic [30:0]           ph_e1 [3];
	logic                  neg_e1 [3];
	logic signed [50:0]    off_e2 [3];
	logic [QUO_W-1:0]      t_c;
	logic signed [15:0]    d_c [3];
	logic signed [16:0]    dn_c [3];
	logic [15:0]           mag_c [3];
	logic [63:0]           sum_c [3];
	logic [49:0]           m_c [3];
	logic signed [31:0]    o_c [3];
	logic signed [31:0]    pt_c [3];

	// Output register.
	logic                  out_v_q;
	logic signed [31:0]    px_q, py_q, pz_q;
	rvcp_pkg::status_t     status_q;

	// The chain moves whenever the output register is free or being emptied.
	assign adv       = !out_v_q || point.ready;
	assign ray.ready = adv;
	assign cfg.ready = 1'b1;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x_q <= '0;
			axis_y_q <= '0;
			radius_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				rvcp_pkg::REG_AXIS_X:     axis_x_q <= cfg.data;
				rvcp_pkg::REG_AXIS_Y:     axis_y_q <= cfg.data;
				rvcp_pkg::REG_CYL_RADIUS: radius_q <= cfg.data[30:0];
				default: ;
			endcase
		end
	end

	// Front end valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			sq_v[0] <= 1'b0;
		end else if (adv) begin
			v_s1 <= ray.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			sq_v[0] <= v_s6;
		end
	end

	assign dxx_c  = ray.dir_x * ray.dir_x;
	assign dyy_c  = ray.dir_y * ray.dir_y;
	assign cneg_c = -cross_s3;
	assign diff_c = {4'b0, lhs_s6} - {1'b0, rhs_s6};

	// Front end: offsets, products, a, h, cross, a*r*r and cross^2.
	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: offsets from the axis, squares of the direction, r*r.
			ray_s1 <= '{ox: ray.orig_x, oy: ray.orig_y, oz: ray.orig_z,
				dx: ray.dir_x, dy: ray.dir_y, dz: ray.dir_z};
			ddx_s1 <= $signed({ray.orig_x[31], ray.orig_x}) - $signed({axis_x_q[31], axis_x_q});
			ddy_s1 <= $signed({ray.orig_y[31], ray.orig_y}) - $signed({axis_y_q[31], axis_y_q});
			dxx_s1 <= dxx_c[30:0];
			dyy_s1 <= dyy_c[30:0];
			rr_s1  <= 62'(radius_q) * 62'(radius_q);

			// Stage 2: a and the four cross products.
			ray_s2 <= ray_s1;
			rr_s2  <= rr_s1;
			a_s2   <= A_W'(dxx_s1) + A_W'(dyy_s1);
			pxx_s2 <= 49'(ray_s1.dx) * 49'(ddx_s1);
			pyy_s2 <= 49'(ray_s1.dy) * 49'(ddy_s1);
			pxy_s2 <= 49'(ray_s1.dx) * 49'(ddy_s1);
			pyx_s2 <= 49'(ray_s1.dy) * 49'(ddx_s1);

			// Stage 3: h, cross, partial products of a*r*r, parallel test.
			ray_s3   <= ray_s2;
			a_s3     <= a_s2;
			h_s3     <= 50'(pxx_s2) + 50'(pyy_s2);
			cross_s3 <= 50'(pxy_s2) - 50'(pyx_s2);
			p0_s3    <= 63'(a_s2) * 63'(rr_s2[30:0]);
			p1_s3    <= 63'(a_s2) * 63'(rr_s2[61:31]);
			par_s3   <= a_s2 <= A_W'(PARALLEL_EPS);

			// Stage 4: a*r*r and the magnitude of cross.
			ray_s4  <= ray_s3;
			a_s4    <= a_s3;
			h_s4    <= h_s3;
			par_s4  <= par_s3;
			lhs_s4  <= 94'(p0_s3) + (94'(p1_s3) << 31);
			cabs_s4 <= cross_s3[49] ? cneg_c[48:0] : cross_s3[48:0];

			// Stage 5: partial products of cross^2.
			ray_s5 <= ray_s4;
			a_s5   <= a_s4;
			h_s5   <= h_s4;
			par_s5 <= par_s4;
			lhs_s5 <= lhs_s4;
			cc0_s5 <= 64'(cabs_s4[31:0]) * 64'(cabs_s4[31:0]);
			cc1_s5 <= 49'(cabs_s4[31:0]) * 49'(cabs_s4[48:32]);
			cc2_s5 <= 34'(cabs_s4[48:32]) * 34'(cabs_s4[48:32]);

			// Stage 6: cross^2.
			ray_s6 <= ray_s5;
			a_s6   <= a_s5;
			h_s6   <= h_s5;
			par_s6 <= par_s5;
			lhs_s6 <= lhs_s5;
			rhs_s6 <= 97'(cc0_s5) + (97'(cc1_s5) << 33) + (97'(cc2_s5) << 64);

			// Stage 7: quarter discriminant and first status.
			sq[0].c.ray <= ray_s6;
			sq[0].c.h   <= h_s6;
			sq[0].c.a   <= a_s6;
			if (par_s6) begin
				sq[0].c.status <= rvcp_pkg::ST_PARALLEL;
			end else if (diff_c[97]) begin
				sq[0].c.status <= rvcp_pkg::ST_NO_ROOT;
			end else begin
				sq[0].c.status <= rvcp_pkg::ST_HIT;
			end
			sq[0].rem  <= diff_c[rvcp_pkg::RAD_W-1:0];
			sq[0].root <= '0;
		end
	end

	// Square root chain, most significant root bit first.
	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		rvcp_sqrt_cell #(.BIT(ROOT_W - 1 - i)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.in_v  (sq_v[i]),
			.in_d  (sq[i]),
			.out_v (sq_v[i+1]),
			.out_d (sq[i+1])
		);
	end

	// Root numerators: the nearer one that is not behind the origin.
	assign hx_c = 51'(sq[ROOT_W].c.h);
	assign sx_c = $signed({4'b0, sq[ROOT_W].root});
	assign n0_c = -hx_c - sx_c;
	assign n1_c = -hx_c + sx_c;

	// Carried data with the behind test folded into the status.
	always_comb begin
		c8_c = sq[ROOT_W].c;
		if (sq[ROOT_W].c.status == rvcp_pkg::ST_HIT && n1_c[50]) begin
			c8_c.status = rvcp_pkg::ST_BEHIND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8    <= 1'b0;
			dv_v[0] <= 1'b0;
		end else if (adv) begin
			v_s8    <= sq_v[ROOT_W];
			dv_v[0] <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 8: numerator choice and the behind test.
			c_s8 <= c8_c;
			n_s8 <= n0_c[50] ? n1_c[49:0] : n0_c[49:0];

			// Stage 9: dividend and the early saturation test of t.
			dv[0].c   <= c_s8;
			dv[0].rem <= {n_s8, {rvcp_pkg::FRAC_W{1'b0}}};
			dv[0].quo <= '0;
			dv[0].ovf <= 66'(n_s8) >= (66'(c_s8.a) << 33);
		end
	end

	// Divider chain, most significant quotient bit first.
	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		rvcp_div_cell #(.BIT(QUO_W - 1 - i)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.in_v  (dv_v[i]),
			.in_d  (dv[i]),
			.out_v (dv_v[i+1]),
			.out_d (dv[i+1])
		);
	end

	// Back end combinational terms per axis.
	assign t_c = dv[QUO_W].ovf ? '1 : dv[QUO_W].quo;

	always_comb begin
		d_c[0] = dv[QUO_W].c.ray.dx;
		d_c[1] = dv[QUO_W].c.ray.dy;
		d_c[2] = dv[QUO_W].c.ray.dz;
		o_c[0] = ray_e2.ox;
		o_c[1] = ray_e2.oy;
		o_c[2] = ray_e2.oz;
		for (int k = 0; k < 3; k++) begin
			dn_c[k]  = -17'(d_c[k]);
			mag_c[k] = d_c[k][15] ? dn_c[k][15:0] : d_c[k];
			sum_c[k] = 64'(pl_e1[k]) + (64'(ph_e1[k]) << 32);
			m_c[k]   = sum_c[k][63:14];
			pt_c[k]  = rvcp_pkg::sat32(52'(o_c[k]) + 52'(off_e2[k]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e1    <= 1'b0;
			v_e2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_e1    <= dv_v[QUO_W];
			v_e2    <= v_e1;
			out_v_q <= v_e2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage e1: partial products of |d| * t.
			ray_e1 <= dv[QUO_W].c.ray;
			st_e1  <= dv[QUO_W].c.status;
			for (int k = 0; k < 3; k++) begin
				pl_e1[k]  <= 48'(mag_c[k]) * 48'(t_c[31:0]);
				ph_e1[k]  <= 31'(mag_c[k]) * 31'(t_c[QUO_W-1:32]);
				neg_e1[k] <= d_c[k][15];
			end

			// Stage e2: signed offsets, truncated toward zero.
			ray_e2 <= ray_e1;
			st_e2  <= st_e1;
			for (int k = 0; k < 3; k++) begin
				off_e2[k] <= neg_e1[k] ? -51'(m_c[k]) : 51'(m_c[k]);
			end

			// Output register: the point on a hit, else the origin.
			status_q <= st_e2;
			if (st_e2 == rvcp_pkg::ST_HIT) begin
				px_q <= pt_c[0];
				py_q <= pt_c[1];
				pz_q <= pt_c[2];
			end else begin
				px_q <= ray_e2.ox;
				py_q <= ray_e2.oy;
				pz_q <= ray_e2.oz;
			end
		end
	end

	assign point.valid      = out_v_q;
	assign point.point_x    = px_q;
	assign point.point_y    = py_q;
	assign point.point_z    = pz_q;
	assign point.hit_status = status_q;

	// The final square root remainder never exceeds twice the root.
	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v[ROOT_W] && sq[ROOT_W].c.status == rvcp_pkg::ST_HIT
		|-> sq[ROOT_W].rem <= rvcp_pkg::RAD_W'({sq[ROOT_W].root, 1'b0}))
		else $error("square root remainder out of range");

	// Without saturation the final division remainder is below a.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v[QUO_W] && dv[QUO_W].c.status == rvcp_pkg::ST_HIT && !dv[QUO_W].ovf
		|-> dv[QUO_W].rem < rvcp_pkg::DVD_W'(dv[QUO_W].c.a))
		else $error("divider remainder not below divisor");

	// A held chain keeps every item in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(sq_v) && $stable(dv_v))
		else $error("cell chain moved during a stall");

	// An accepted item enters the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		ray.valid && ray.ready |=> v_s1)
		else $error("accepted item lost at the first stage");

endmodule

@@ bench/rvcp_checker.sv @@
// Checker for the ray / vertical cylinder projection block: watches the three channels,
// predicts each point item and compares it field by field with the block's output.
// Depends on rvcp_pkg and rvcp_if.
module rvcp_checker
	import rvcp_pkg::*;
#(
	parameter int unsigned PARALLEL_EPS = PARALLEL_EPS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	rvcp_ray_if   ray,
	rvcp_point_if point,
	rvcp_cfg_if   cfg,
	output int    errors,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint T_LIMIT = 64'h7FFF_FFFF_FFFF;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		status_t            st;
	} point_t;

	// Shadow copy of the configuration registers.
	logic signed [31:0] axis_x_q;
	logic signed [31:0] axis_y_q;
	logic [30:0]        radius_q;

	point_t expected_points[$];

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sh7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sh8000_0000) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Direction component times t, back to Q.8, truncated toward zero.
	function automatic longint step_along(logic signed [15:0] d, longint t);
		longint unsigned mag;
		mag = d < 0 ? longint'(-longint'(d)) : longint'(d);
		mag = (mag * longint'(t)) >> 14;
		return d < 0 ? -longint'(mag) : longint'(mag);
	endfunction

	// Nearest non-negative intersection of the ray with the cylinder wall.
	function automatic point_t project_ray(ray_t r);
		longint ddx, ddy, a, h, cr, n, quo, rem, t;
		longint unsigned ucr;
		logic [127:0] lhs, rhs, rad, root, cand;
		point_t p;
		p.x = r.ox;
		p.y = r.oy;
		p.z = r.oz;
		p.st = ST_PARALLEL;
		ddx = longint'(r.ox) - longint'(axis_x_q);
		ddy = longint'(r.oy) - longint'(axis_y_q);
		a = longint'(r.dx) * longint'(r.dx) + longint'(r.dy) * longint'(r.dy);
		if (a <= longint'(PARALLEL_EPS) || a == 0) begin
			return p;
		end
		h = longint'(r.dx) * ddx + longint'(r.dy) * ddy;
		cr = longint'(r.dx) * ddy - longint'(r.dy) * ddx;
		ucr = cr < 0 ? -cr : cr;
		lhs = 128'(a);
		lhs = lhs * 128'(radius_q);
		lhs = lhs * 128'(radius_q);
		rhs = 128'(ucr);
		rhs = rhs * rhs;
		if (lhs < rhs) begin
			p.st = ST_NO_ROOT;
			return p;
		end
		rad = lhs - rhs;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = root | (128'd1 << b);
			if (cand * cand <= rad) begin
				root = cand;
			end
		end
		n = -h - longint'(root[63:0]);
		if (n < 0) begin
			n = -h + longint'(root[63:0]);
		end
		if (n < 0) begin
			p.st = ST_BEHIND;
			return p;
		end
		quo = n / a;
		rem = n % a;
		if (quo >= (64'sd1 <<< 33)) begin
			t = T_LIMIT;
		end else begin
			t = (quo <<< 14) + (rem <<< 14) / a;
			if (t > T_LIMIT) begin
				t = T_LIMIT;
			end
		end
		p.x = clamp32(longint'(r.ox) + step_along(r.dx, t));
		p.y = clamp32(longint'(r.oy) + step_along(r.dy, t));
		p.z = clamp32(longint'(r.oz) + step_along(r.dz, t));
		p.st = ST_HIT;
		return p;
	endfunction

	task automatic report(string what, longint want, longint got);
		$display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		errors++;
	endtask

	// Track configuration, queue predictions and check every point item.
	always @(posedge clk or negedge arst_n) begin
		point_t e;
		ray_t r;
		if (!arst_n) begin
			axis_x_q <= '0;
			axis_y_q <= '0;
			radius_q <= '0;
			expected_points.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_AXIS_X:     axis_x_q <= cfg.data;
					REG_AXIS_Y:     axis_y_q <= cfg.data;
					REG_CYL_RADIUS: radius_q <= cfg.data[30:0];
					default: ;
				endcase
			end
			if (point.valid && point.ready) begin
				if (expected_points.size() == 0) begin
					$display("%0t point item with no ray waiting", $time);
					errors++;
				end else begin
					e = expected_points.pop_front();
					if (point.point_x !== e.x) report("point_x", e.x, point.point_x);
					if (point.point_y !== e.y) report("point_y", e.y, point.point_y);
					if (point.point_z !== e.z) report("point_z", e.z, point.point_z);
					if (point.hit_status !== e.st) report("hit_status", e.st, point.hit_status);
				end
			end
			if (ray.valid && ray.ready) begin
				r.ox = ray.orig_x;
				r.oy = ray.orig_y;
				r.oz = ray.orig_z;
				r.dx = ray.dir_x;
				r.dy = ray.dir_y;
				r.dz = ray.dir_z;
				expected_points.push_back(project_ray(r));
			end
			pending = expected_points.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
// Top of the testbench: clock, reset, ray and configuration stimulus, output stalls
// and the verdict. Depends on rvcp_pkg, rvcp_if, rvcp_checker and the block itself.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rvcp_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int DRAIN_CYCLES = 130;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	int   rays_sent = 0;
	int   settings_run = 0;
	bit   no_idle = 1'b0;
	bit   hold_req = 1'b0;

	rvcp_ray_if   ray_ch ();
	rvcp_point_if pt_ch ();
	rvcp_cfg_if   cfg_ch ();

	ray_vertical_cylinder_projection uut (
		.clk(clk), .arst_n(arst_n), .ray(ray_ch), .point(pt_ch), .cfg(cfg_ch)
	);

	rvcp_checker chk (
		.clk(clk), .arst_n(arst_n), .ray(ray_ch), .point(pt_ch), .cfg(cfg_ch),
		.errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	// Hard limit on the run time.
	initial begin
		#5ms;
		$display("timeout with %0d point items outstanding", pending);
		$display("== FAIL ==");
		$finish;
	end

	// Output side: random stall bursts, one long hold-off on request.
	initial begin
		int len;
		pt_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (no_idle) begin
				pt_ch.ready <= 1'b1;
			end else if (hold_req) begin
				pt_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				len = $urandom_range(1, 17);
				pt_ch.ready <= ($urandom_range(0, 2) != 0);
				repeat (len - 1) @(posedge clk);
			end
		end
	end

	// Wait for the handshake; ready is sampled mid-cycle, where it is settled.
	task automatic wait_ray_accept();
		bit acc;
		do begin
			@(negedge clk);
			acc = ray_ch.ready;
			@(posedge clk);
		end while (!acc);
	endtask

	task automatic send_ray(ray_t r, bit gaps);
		ray_ch.valid  <= 1'b1;
		ray_ch.orig_x <= r.ox;
		ray_ch.orig_y <= r.oy;
		ray_ch.orig_z <= r.oz;
		ray_ch.dir_x  <= r.dx;
		ray_ch.dir_y  <= r.dy;
		ray_ch.dir_z  <= r.dz;
		wait_ray_accept();
		rays_sent++;
		if (gaps && !no_idle && $urandom_range(0, 3) == 0) begin
			ray_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Let the pipeline empty, including items still in flight.
	task automatic wait_drained();
		ray_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		bit acc;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do begin
			@(negedge clk);
			acc = cfg_ch.ready;
			@(posedge clk);
		end while (!acc);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_cylinder(logic [31:0] ax, logic [31:0] ay, logic [31:0] rad);
		wait_drained();
		write_reg(REG_AXIS_X, ax);
		write_reg(REG_AXIS_Y, ay);
		write_reg(REG_CYL_RADIUS, rad);
		settings_run++;
	endtask

	function automatic ray_t make_ray(longint ox, longint oy, longint oz,
			longint dx, longint dy, longint dz);
		ray_t r;
		r.ox = ox[31:0];
		r.oy = oy[31:0];
		r.oz = oz[31:0];
		r.dx = dx[15:0];
		r.dy = dy[15:0];
		r.dz = dz[15:0];
		return r;
	endfunction

	// Random ray: mostly aimed around the cylinder, some near-vertical, some raw bits.
	function automatic ray_t random_ray(longint ax, longint ay, longint rad);
		ray_t r;
		longint span;
		int kind;
		kind = $urandom_range(0, 19);
		r.ox = $urandom;
		r.oy = $urandom;
		r.oz = $urandom;
		r.dx = 16'($urandom);
		r.dy = 16'($urandom);
		r.dz = 16'($urandom);
		if (kind < 14) begin
			span = rad * 3 + 256;
			if (span > 64'sh7FFF_FFFF) span = 64'sh7FFF_FFFF;
			r.ox = 32'(ax + longint'($urandom_range(0, 32'(2 * span))) - span);
			r.oy = 32'(ay + longint'($urandom_range(0, 32'(2 * span))) - span);
			r.dx = 16'($urandom_range(0, 32768) - 16384);
			r.dy = 16'($urandom_range(0, 32768) - 16384);
			r.dz = 16'($urandom_range(0, 32768) - 16384);
		end else if (kind < 17) begin
			r.dx = 16'($urandom_range(0, 400) - 200);
			r.dy = 16'($urandom_range(0, 400) - 200);
		end
		return r;
	endfunction

	task automatic random_phase(longint ax, longint ay, longint rad, int count);
		set_cylinder(ax[31:0], ay[31:0], rad[31:0]);
		repeat (count) send_ray(random_ray(ax, ay, rad), 1'b1);
	endtask

	initial begin
		longint ax, ay, rr;
		ray_ch.valid = 1'b0;
		ray_ch.orig_x = '0;
		ray_ch.orig_y = '0;
		ray_ch.orig_z = '0;
		ray_ch.dir_x = '0;
		ray_ch.dir_y = '0;
		ray_ch.dir_z = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero radius at the origin.
		send_ray(make_ray(0, 0, 0, 16384, 0, 0), 1'b0);
		send_ray(make_ray(256, 0, 100, -16384, 0, 0), 1'b0);

		// Directed rays against a mid-sized cylinder.
		ax = 1000 * 256;
		ay = -500 * 256;
		rr = 100 * 256;
		set_cylinder(ax[31:0], ay[31:0], rr[31:0]);
		write_reg(REG_SPARE, 32'hDEAD_BEEF);
		send_ray(make_ray(ax, ay, 0, 16384, 0, 0), 1'b0);
		send_ray(make_ray(ax - 300 * 256, ay, 5, 16384, 0, 16384), 1'b0);
		send_ray(make_ray(ax - 300 * 256, ay, 5, -16384, 0, 0), 1'b0);
		send_ray(make_ray(ax - 300 * 256, ay + 200 * 256, 0, 16384, 0, 0), 1'b0);
		send_ray(make_ray(ax, ay, 7, 0, 0, 16384), 1'b0);
		send_ray(make_ray(ax, ay, 7, 163, 0, 16384), 1'b0);
		send_ray(make_ray(ax, ay, 7, 164, 0, 16384), 1'b0);
		send_ray(make_ray(ax, ay, 0, -32768, -32768, -32768), 1'b0);
		send_ray(make_ray(ax - 300 * 256, ay, 0, 11585, 11585, -16384), 1'b0);
		send_ray(make_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			16384, 16384, 16384), 1'b0);
		send_ray(make_ray(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
			-16384, -16384, -16384), 1'b0);
		send_ray(make_ray(ax - rr, ay, 0, 0, 16384, 0), 1'b0);

		// Extreme radius and axis: huge t and saturated points.
		set_cylinder(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_ray(make_ray(32'sh7FFF_FFFF, -64'sh8000_0000, 0, 164, 0, 16384), 1'b0);
		send_ray(make_ray(0, 0, 32'sh7FFF_FFFF, 16384, -16384, 16384), 1'b0);
		send_ray(make_ray(-64'sh8000_0000, 32'sh7FFF_FFFF, 0, -32768, 32767, 32767), 1'b0);
		send_ray(make_ray(0, 0, 0, 0, 32767, -32768), 1'b0);

		// Long output hold-off while rays keep coming, so the input backs up.
		set_cylinder(32'd0, 32'd0, 32'd5000);
		hold_req = 1'b1;
		repeat (160) send_ray(random_ray(0, 0, 5000), 1'b0);

		// Random phases under several cylinder settings.
		random_phase(0, 0, 5000, 90);
		random_phase(-64'sh8000_0000, 32'sh7FFF_FFFF, 64'sh7FFF_FFFF, 140);
		random_phase(12345, -987654, 0, 100);
		random_phase($urandom, $urandom, $urandom_range(0, 32'h7FFF_FFFF), 140);
		random_phase(-200000, 300000, $urandom_range(1, 200000), 100);

		// Last stretch without idling on either side.
		set_cylinder($urandom, $urandom, $urandom_range(0, 50000));
		no_idle = 1'b1;
		repeat (130) send_ray(random_ray(0, 0, 50000), 1'b1);

		wait_drained();
		$display("Sent %0d rays under %0d cylinder settings, with stalls, a long hold-off",
			rays_sent, settings_run);
		$display("and parallel, missing, behind, saturating and raw-bit rays.");
		if (errors == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
